>>> rtl/mcoc_pkg.sv
package mcoc_pkg;

	localparam int MAX_DIMS = 64;
	localparam int DIM_BITS = 16;

	localparam int DIM_IN_W = 16;
	localparam int COST_W   = 54;
	localparam int SPLIT_W  = 6;
	localparam int STATUS_W = 2;

	localparam int IDX_W  = $clog2(MAX_DIMS);
	localparam int CNT_W  = $clog2(MAX_DIMS + 1);
	localparam int ADDR_W = 2 * IDX_W;

	localparam int MUL1_W = 2 * DIM_BITS;
	localparam int PROD_W = 3 * DIM_BITS;
	localparam int WIDE_W = (PROD_W > COST_W) ? PROD_W : COST_W;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FEW  = 2'd1,
		STATUS_MANY = 2'd2,
		STATUS_SAT  = 2'd3
	} status_t;

	typedef struct packed {
		logic [DIM_IN_W-1:0] dim_value;
		logic                last;
	} mcoc_in_t;

	typedef struct packed {
		logic [COST_W-1:0]   min_cost;
		logic [SPLIT_W-1:0]  top_split;
		logic [STATUS_W-1:0] status;
	} mcoc_out_t;

	// One split candidate handed from the sequencer to the step unit.
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              zero_b;
		logic [IDX_W-1:0]  k;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
	} step_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} cost_wr_t;

endpackage

>>> rtl/matrix_chain_order_cost.sv
// Matrix chain order cost.
// The dims channel carries one request per dimension p0..pn of a chain, in
// chain order; the request with last set closes the chain. Each dimension is
// written to a 64-entry store; dimensions beyond the store are dropped and
// flagged. After last, the block fills the interval cost table bottom-up over
// chain lengths with one pipelined step unit: two cost-table reads, two
// multiplies, two saturating adds and a compare, one split candidate entering
// per cycle. Each interval of L matrices fetches its two outer dimensions,
// issues its L-1 split candidates, drains the pipeline and writes its minimum
// through the single cost-table write port. The result channel then presents
// one request with the minimum cost, the outermost split and a status.
// dims_ready is low while a chain is solved. A result held by a stalled
// receiver sits in the output register; the next chain still loads, and only
// a second result waits for it.
// Reset clears the control state; the stores need no clearing pass.
module matrix_chain_order_cost (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dims_valid,
	output logic                 dims_ready,
	input  mcoc_pkg::mcoc_in_t   dims,
	output logic                 result_valid,
	input  logic                 result_ready,
	output mcoc_pkg::mcoc_out_t  result
);

	typedef enum logic [8:0] {
		S_LOAD    = 9'b000000001,
		S_CHECK   = 9'b000000010,
		S_FETCH_A = 9'b000000100,
		S_FETCH_B = 9'b000001000,
		S_FETCH_C = 9'b000010000,
		S_STEP    = 9'b000100000,
		S_DRAIN   = 9'b001000000,
		S_WRITE   = 9'b010000000,
		S_FINISH  = 9'b100000000
	} state_t;

	state_t state_q;

	// Dimension store, one write per accepted request that fits, one registered read.
	logic [mcoc_pkg::DIM_BITS-1:0] dims_mem [mcoc_pkg::MAX_DIMS];
	logic [mcoc_pkg::DIM_BITS-1:0] dim_rd_q;
	logic [mcoc_pkg::IDX_W-1:0]    dim_addr;

	logic [mcoc_pkg::CNT_W-1:0] count_q, n_q;
	logic                       ovf_q, ovf_last_q;

	// Current interval (i, j) and split candidate k, all 1-based.
	logic [mcoc_pkg::IDX_W-1:0]    i_q, j_q, k_q;
	logic [mcoc_pkg::DIM_BITS-1:0] p_im1_q, p_j_q;

	mcoc_pkg::mcoc_out_t pend_q, out_q;
	logic                out_valid_q;

	logic accept, store_ok, last_j;

	mcoc_pkg::step_t             step;
	mcoc_pkg::cost_wr_t          wr;
	logic [mcoc_pkg::COST_W-1:0] best;
	logic [mcoc_pkg::IDX_W-1:0]  best_k;
	logic                        busy;

	assign dims_ready = (state_q == S_LOAD);
	assign accept     = dims_valid && dims_ready;
	assign store_ok   = (count_q < mcoc_pkg::CNT_W'(mcoc_pkg::MAX_DIMS));

	always_comb begin
		unique case (state_q)
			S_FETCH_A: dim_addr = i_q - mcoc_pkg::IDX_W'(1);
			S_FETCH_B: dim_addr = j_q;
			default:   dim_addr = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && store_ok) begin
			dims_mem[count_q[mcoc_pkg::IDX_W-1:0]] <= mcoc_pkg::DIM_BITS'(dims.dim_value);
		end
		dim_rd_q <= dims_mem[dim_addr];
	end

	// While stepping, k runs from i to j-1; cost(i,i) and cost(j,j) read as zero.
	always_comb begin
		step.valid  = (state_q == S_STEP);
		step.first  = (k_q == i_q);
		step.zero_b = ((k_q + mcoc_pkg::IDX_W'(1)) == j_q);
		step.k      = k_q;
		step.addr_a = {i_q, k_q};
		step.addr_b = {k_q + mcoc_pkg::IDX_W'(1), j_q};
	end

	assign wr.en   = (state_q == S_WRITE);
	assign wr.addr = {i_q, j_q};

	// The whole chain's interval is the last one of the longest length.
	assign last_j = (mcoc_pkg::CNT_W'(j_q) == n_q - mcoc_pkg::CNT_W'(1));

	mcoc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.dim_k  (dim_rd_q),
		.p_im1  (p_im1_q),
		.p_j    (p_j_q),
		.wr     (wr),
		.best   (best),
		.best_k (best_k),
		.busy   (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			ovf_last_q  <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			p_im1_q     <= '0;
			p_j_q       <= '0;
			pend_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The finish state reloads the output register itself.
			if (out_valid_q && result_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (dims.last) begin
							// Close the chain and start a fresh one behind it.
							n_q        <= store_ok ? count_q + mcoc_pkg::CNT_W'(1) : count_q;
							ovf_last_q <= ovf_q | ~store_ok;
							count_q    <= '0;
							ovf_q      <= 1'b0;
							state_q    <= S_CHECK;
						end else if (store_ok) begin
							count_q <= count_q + mcoc_pkg::CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_CHECK: begin
					if (ovf_last_q) begin
						pend_q  <= '{min_cost: '0, top_split: '0,
							status: mcoc_pkg::STATUS_MANY};
						state_q <= S_FINISH;
					end else if (n_q < mcoc_pkg::CNT_W'(2)) begin
						pend_q  <= '{min_cost: '0, top_split: '0,
							status: mcoc_pkg::STATUS_FEW};
						state_q <= S_FINISH;
					end else if (n_q == mcoc_pkg::CNT_W'(2)) begin
						pend_q  <= '{min_cost: '0, top_split: '0,
							status: mcoc_pkg::STATUS_OK};
						state_q <= S_FINISH;
					end else begin
						i_q     <= mcoc_pkg::IDX_W'(1);
						j_q     <= mcoc_pkg::IDX_W'(2);
						state_q <= S_FETCH_A;
					end
				end
				S_FETCH_A: begin
					state_q <= S_FETCH_B;
				end
				S_FETCH_B: begin
					p_im1_q <= dim_rd_q;
					state_q <= S_FETCH_C;
				end
				S_FETCH_C: begin
					p_j_q   <= dim_rd_q;
					k_q     <= i_q;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (k_q == j_q - mcoc_pkg::IDX_W'(1)) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + mcoc_pkg::IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (!busy) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (last_j) begin
						if (i_q == mcoc_pkg::IDX_W'(1)) begin
							pend_q  <= '{min_cost: best,
								top_split: mcoc_pkg::SPLIT_W'(best_k),
								status: (best == mcoc_pkg::COST_MAX)
									? mcoc_pkg::STATUS_SAT : mcoc_pkg::STATUS_OK};
							state_q <= S_FINISH;
						end else begin
							// Next chain length starts again at the left end.
							j_q     <= j_q - i_q + mcoc_pkg::IDX_W'(2);
							i_q     <= mcoc_pkg::IDX_W'(1);
							state_q <= S_FETCH_A;
						end
					end else begin
						i_q     <= i_q + mcoc_pkg::IDX_W'(1);
						j_q     <= j_q + mcoc_pkg::IDX_W'(1);
						state_q <= S_FETCH_A;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || result_ready) begin
						out_q       <= pend_q;
						out_valid_q <= 1'b1;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> rtl/mcoc_dp.sv
module mcoc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcoc_pkg::step_t               step,
	input  logic [mcoc_pkg::DIM_BITS-1:0] dim_k,
	input  logic [mcoc_pkg::DIM_BITS-1:0] p_im1,
	input  logic [mcoc_pkg::DIM_BITS-1:0] p_j,
	input  mcoc_pkg::cost_wr_t            wr,
	output logic [mcoc_pkg::COST_W-1:0]   best,
	output logic [mcoc_pkg::IDX_W-1:0]    best_k,
	output logic                          busy
);

	localparam int DEPTH = mcoc_pkg::MAX_DIMS * mcoc_pkg::MAX_DIMS;

	// Interval cost table, addressed {i, j}.
	logic [mcoc_pkg::COST_W-1:0] cost_mem [DEPTH];

	logic [mcoc_pkg::COST_W-1:0] rd_a_s1, rd_b_s1;
	mcoc_pkg::step_t             ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic [mcoc_pkg::COST_W-1:0] ab_s2, ab_s3, ab_s4, prod_s4, t_s5;
	logic [mcoc_pkg::MUL1_W-1:0] m1_s2;
	logic [mcoc_pkg::PROD_W-1:0] prod_s3;

	logic [mcoc_pkg::COST_W-1:0] best_q;
	logic [mcoc_pkg::IDX_W-1:0]  best_k_q;

	logic [mcoc_pkg::COST_W-1:0] a_s1, b_s1, ab_sat, prod_sat, t_sat;
	logic [mcoc_pkg::COST_W:0]   ab_sum, t_sum;
	logic [mcoc_pkg::MUL1_W-1:0] mul1;
	logic [mcoc_pkg::PROD_W-1:0] mul2;
	logic [mcoc_pkg::WIDE_W-1:0] prod_wide;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			cost_mem[wr.addr] <= best_q;
		end
		rd_a_s1 <= cost_mem[step.addr_a];
		rd_b_s1 <= cost_mem[step.addr_b];
	end

	// The one-length intervals cost nothing and are never stored.
	assign a_s1   = ctl_s1.first ? '0 : rd_a_s1;
	assign b_s1   = ctl_s1.zero_b ? '0 : rd_b_s1;
	assign ab_sum = {1'b0, a_s1} + {1'b0, b_s1};
	assign ab_sat = (ab_sum >= {1'b0, mcoc_pkg::COST_MAX}) ? mcoc_pkg::COST_MAX
		: ab_sum[mcoc_pkg::COST_W-1:0];
	assign mul1   = mcoc_pkg::MUL1_W'(p_im1) * mcoc_pkg::MUL1_W'(dim_k);

	assign mul2 = mcoc_pkg::PROD_W'(m1_s2) * mcoc_pkg::PROD_W'(p_j);

	assign prod_wide = mcoc_pkg::WIDE_W'(prod_s3);
	assign prod_sat  = (prod_wide > mcoc_pkg::WIDE_W'(mcoc_pkg::COST_MAX))
		? mcoc_pkg::COST_MAX : prod_wide[mcoc_pkg::COST_W-1:0];

	assign t_sum = {1'b0, ab_s4} + {1'b0, prod_s4};
	assign t_sat = (t_sum >= {1'b0, mcoc_pkg::COST_MAX}) ? mcoc_pkg::COST_MAX
		: t_sum[mcoc_pkg::COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s1 <= step;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		ab_s2   <= ab_sat;
		m1_s2   <= mul1;
		ab_s3   <= ab_s2;
		prod_s3 <= mul2;
		ab_s4   <= ab_s3;
		prod_s4 <= prod_sat;
		t_s5    <= t_sat;
		// The first candidate always wins; later ones only when strictly lower.
		if (ctl_s5.valid && (ctl_s5.first || t_s5 < best_q)) begin
			best_q   <= t_s5;
			best_k_q <= ctl_s5.k;
		end
	end

	assign best   = best_q;
	assign best_k = best_k_q;
	assign busy   = ctl_s1.valid | ctl_s2.valid | ctl_s3.valid | ctl_s4.valid
		| ctl_s5.valid;

endmodule

>>> rtl/mcoc_checker.sv
module mcoc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                dims_valid,
	input logic                dims_ready,
	input mcoc_pkg::mcoc_in_t  dims,
	input logic                result_valid,
	input logic                result_ready,
	input mcoc_pkg::mcoc_out_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		dims_valid && dims_ready && dims.last |=> !dims_ready)
		else $error("dims still taken right after a chain closed");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!dims_ready))
		else $error("result appeared while loading dimensions");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == mcoc_pkg::STATUS_FEW
			|| result.status == mcoc_pkg::STATUS_MANY)
		|-> result.min_cost == '0 && result.top_split == '0)
		else $error("error result carries a cost or split");

	a_sat_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == mcoc_pkg::STATUS_SAT
			|| result.status == mcoc_pkg::STATUS_OK)
		|-> ((result.min_cost == mcoc_pkg::COST_MAX)
			== (result.status == mcoc_pkg::STATUS_SAT)))
		else $error("saturation status does not match the cost");

endmodule

bind matrix_chain_order_cost mcoc_checker u_mcoc_checker (.*);
